@@ design/gps_altitude_fallback_blender_assert.svh @@
// Assertion macros for the checker file of the altitude blender.
// Each macro states one clocked implication, disabled while rst is high.
`ifndef GPS_ALTITUDE_FALLBACK_BLENDER_ASSERT_SVH
`define GPS_ALTITUDE_FALLBACK_BLENDER_ASSERT_SVH

// Same-cycle implication: when pre holds, post holds in that cycle.
`define GAFB_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication: when pre holds, post holds in the next cycle.
`define GAFB_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/gafb_pkg.sv @@
package gafb_pkg;

  // Block sizing
  localparam int HISTORY_DEPTH = 10;
  localparam int GOOD_WAIT     = 10;
  localparam int RAMP_DELAY    = 2;

  // Field widths
  localparam int ALT_W     = 24;
  localparam int SLOPE_W   = 17;
  localparam int THR_W     = 23;
  localparam int STATUS_W  = 16;
  localparam int MODE_W    = 4;
  localparam int CNT_W     = 4;
  localparam int SLOPE_FRAC = 16;

  // Receiver quality codes
  localparam logic [STATUS_W-1:0] GOOD_STATUS_NONE = '0;
  localparam logic [STATUS_W-1:0] GOOD_STATUS_ALT  = 16'h0b00;
  localparam logic [MODE_W-1:0]   MIN_GOOD_MODE    = 4'd4;
  localparam logic [CNT_W-1:0]    CNT_MAX          = '1;

  // Configuration register reset values
  localparam logic [SLOPE_W-1:0]       FIT_SLOPE_RST      = 17'd64138;
  localparam logic signed [ALT_W-1:0]  FIT_INTERCEPT_RST  = -24'sd11850;
  localparam logic [THR_W-1:0]         JUMP_THRESHOLD_RST = 23'd12800;

  // Internal datapath widths
  localparam int OFF_W    = 25;
  localparam int FIT_W    = 28;
  localparam int EST_W    = 29;
  localparam int DEV_W    = 30;
  localparam int MUL_A_W  = 30;
  localparam int MUL_P_W  = MUL_A_W + SLOPE_W + 1;
  localparam int RND_HALF = 1 << (SLOPE_FRAC - 1);
  localparam int SUM_W    = OFF_W + $clog2(HISTORY_DEPTH);
  localparam int SLOT_W   = $clog2(HISTORY_DEPTH);
  localparam int SWEEP_W  = $clog2(HISTORY_DEPTH + 1);

  // Divider sizing: DIV_STEP quotient bits per cycle
  localparam int DIV_W       = 36;
  localparam int DIV_STEP    = 4;
  localparam int DIV_DEN_W   = 6;
  localparam int DIV_ITERS   = DIV_W / DIV_STEP;
  localparam int DIV_ITER_W  = $clog2(DIV_ITERS + 1);
  localparam int MEAN_DEN    = HISTORY_DEPTH - 1;
  localparam int RAMP_DEN_RAW = 1 + GOOD_WAIT - RAMP_DELAY;
  localparam int RAMP_DEN    = (RAMP_DEN_RAW < 1) ? 1 : RAMP_DEN_RAW;
  localparam int RES_W       = DIV_W + 1;

  // Saturation limits
  localparam logic signed [ALT_W-1:0] ALT_MAX_V = {1'b0, {(ALT_W-1){1'b1}}};
  localparam logic signed [ALT_W-1:0] ALT_MIN_V = {1'b1, {(ALT_W-1){1'b0}}};
  localparam logic signed [OFF_W-1:0] OFF_MAX_V = {1'b0, {(OFF_W-1){1'b1}}};
  localparam logic signed [OFF_W-1:0] OFF_MIN_V = {1'b1, {(OFF_W-1){1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_SLOPE      = 2'd0,
    CFG_FIT_INTERCEPT  = 2'd1,
    CFG_JUMP_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ALT_W-1:0] gps_alt;
    logic                    gps_alt_missing;
    logic signed [ALT_W-1:0] ref_alt;
    logic                    ref_alt_missing;
    logic [STATUS_W-1:0]     gps_status;
    logic [MODE_W-1:0]       gps_mode;
  } in_t;

  typedef struct packed {
    logic signed [ALT_W-1:0] corrected_alt;
    logic                    result_missing;
    logic                    substituted;
  } out_t;

  // Divider handshake
  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] num;
    logic [DIV_DEN_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FIT,
    ST_FIT,
    ST_FILL,
    ST_SWEEP,
    ST_DECIDE,
    ST_DIV_MEAN,
    ST_EST,
    ST_MUL_RAMP,
    ST_RAMP_START,
    ST_DIV_RAMP,
    ST_DONE
  } state_t;

endpackage

@@ design/gafb_div.sv @@
// Signed divide by a small positive divisor, rounded to nearest with ties
// away from zero. Restoring division, DIV_STEP quotient bits per cycle.
module gafb_div
  import gafb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                   busy;
  logic                   done;
  logic [DIV_ITER_W-1:0]  iter;
  logic                   neg;
  logic [DIV_DEN_W-1:0]   den_r;
  logic [DIV_W-1:0]       dq;
  logic [DIV_DEN_W-1:0]   rem;

  logic [DIV_W-1:0]       num_abs;
  logic [DIV_W-1:0]       dq_step;
  logic [DIV_DEN_W-1:0]   rem_step;

  // Magnitude of the numerator
  assign num_abs = req.num[DIV_W-1] ? DIV_W'(-req.num) : DIV_W'(req.num);

  // DIV_STEP restoring steps on the narrow remainder
  always_comb begin
    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] diff;
    dq_step  = dq;
    rem_step = rem;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial   = {rem_step, dq_step[DIV_W-1]};
      dq_step = {dq_step[DIV_W-2:0], 1'b0};
      diff    = trial - {1'b0, den_r};
      if (trial >= {1'b0, den_r}) begin
        rem_step   = diff[DIV_DEN_W-1:0];
        dq_step[0] = 1'b1;
      end else begin
        rem_step = trial[DIV_DEN_W-1:0];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= DIV_ITER_W'(DIV_ITERS);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == DIV_ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath; half the divisor is added up front for rounding
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg   <= req.num[DIV_W-1];
      den_r <= req.den;
      dq    <= num_abs + DIV_W'(req.den >> 1);
      rem   <= '0;
    end else if (busy) begin
      dq  <= dq_step;
      rem <= rem_step;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = neg ? -$signed(dq) : $signed(dq);

endmodule

@@ design/gps_altitude_fallback_blender.sv @@
// GPS altitude fallback blender. Each input item is one low-rate sample (GPS
// altitude, reference altitude, receiver status and mode, missing flags) and
// gives exactly one result item. Good GPS passes through and refreshes a ring
// of GPS-minus-fit offsets; bad GPS is replaced by the reference fit plus the
// mean of the older offsets, and returning GPS is ramped back in. in_ready is
// high only while the block waits for an item. An item with a missing altitude
// goes straight to the output stage; any other item runs the fit and a sweep
// of the ring (one entry per cycle through the single read port of the offset
// memory), and replacement and ramp values also use the shared divider, which
// retires four quotient bits per cycle. Before its sweep, the first sample with
// both altitudes fills every ring entry with its offset. A finished result sits
// in an output register, so the next item is taken while it waits;
// configuration writes take effect at once and belong between items.
module gps_altitude_fallback_blender
  import gafb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [SLOPE_W-1:0]       fit_slope;
  logic signed [ALT_W-1:0]  fit_intercept;
  logic [THR_W-1:0]         jump_threshold;

  // Control state
  logic                     started;
  logic [CNT_W-1:0]         good_count;
  logic                     jump_latched;
  logic [SLOT_W-1:0]        newest_slot;
  logic [CNT_W-1:0]         ramp_step;

  // Working registers
  in_t                      in_r;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [FIT_W-1:0]  fit;
  logic [SWEEP_W-1:0]       cnt;
  logic signed [SUM_W-1:0]  sum;
  logic signed [OFF_W-1:0]  ring_slot;
  logic [SLOT_W-1:0]        rd_idx;
  logic                     rd_ok;
  logic signed [EST_W-1:0]  est;
  logic signed [RES_W-1:0]  res;
  logic                     res_missing;
  logic                     res_subst;

  // Offset memory
  logic signed [OFF_W-1:0]  ring [HISTORY_DEPTH];
  logic signed [OFF_W-1:0]  rd_data;
  logic [SLOT_W-1:0]        ring_raddr;
  logic                     ring_we;
  logic [SLOT_W-1:0]        ring_waddr;

  // Shared divider
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Combinational datapath
  logic signed [MUL_A_W-1:0] mul_a;
  logic [SLOPE_W-1:0]        mul_b;
  logic signed [SLOPE_W:0]   mul_b_s;
  logic signed [MUL_P_W-1:0] rnd;
  logic signed [MUL_P_W-1:0] rnd_sh;
  logic signed [FIT_W:0]     off_diff;
  logic signed [OFF_W-1:0]   offset;
  logic signed [DEV_W-1:0]   dev;
  logic [DEV_W-1:0]          dev_abs;
  logic                      status_good;
  logic                      mode_good;
  logic [CNT_W-1:0]          gc_calc;
  logic                      jl_set;
  logic                      pass;
  logic                      replace;
  logic [SLOT_W-1:0]         slot_inc;
  logic                      in_missing;
  logic                      out_load;
  logic signed [ALT_W-1:0]   res_sat;

  assign in_ready   = (state == ST_IDLE);
  assign in_missing = in_data.gps_alt_missing | in_data.ref_alt_missing;

  // Shared multiplier operands: fit product or ramp product
  assign mul_a   = (state == ST_MUL_RAMP) ? MUL_A_W'(MUL_A_W'(in_r.gps_alt) - MUL_A_W'(est))
                                          : MUL_A_W'(in_r.ref_alt);
  assign mul_b   = (state == ST_MUL_RAMP) ? SLOPE_W'(ramp_step) : fit_slope;
  assign mul_b_s = $signed({1'b0, mul_b});

  // Q16 rounding, ties toward plus infinity
  assign rnd    = prod + MUL_P_W'(RND_HALF);
  assign rnd_sh = rnd >>> SLOPE_FRAC;

  // Offset against the fit, saturated to the ring width
  assign off_diff = (FIT_W + 1)'(in_r.gps_alt) - (FIT_W + 1)'(fit);
  always_comb begin
    if (off_diff > (FIT_W + 1)'(OFF_MAX_V)) begin
      offset = OFF_MAX_V;
    end else if (off_diff < (FIT_W + 1)'(OFF_MIN_V)) begin
      offset = OFF_MIN_V;
    end else begin
      offset = OFF_W'(off_diff);
    end
  end

  // Jump check against the newest offset
  assign dev     = DEV_W'(in_r.gps_alt) - DEV_W'(fit) - DEV_W'(ring_slot);
  assign dev_abs = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);

  // Good-data counter update
  assign status_good = (in_r.gps_status == GOOD_STATUS_NONE) ||
                       (in_r.gps_status == GOOD_STATUS_ALT);
  assign mode_good   = (in_r.gps_mode >= MIN_GOOD_MODE);
  assign jl_set      = !jump_latched && (dev_abs > DEV_W'(jump_threshold));
  always_comb begin
    gc_calc = (good_count == CNT_MAX) ? good_count : good_count + 1'b1;
    if (!status_good || !mode_good || jl_set) begin
      gc_calc = '0;
    end
  end
  assign pass     = (gc_calc >= CNT_W'(GOOD_WAIT));
  assign replace  = (good_count < CNT_W'(RAMP_DELAY)) || !mode_good;
  assign slot_inc = (newest_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : newest_slot + 1'b1;

  assign ring_raddr = cnt[SLOT_W-1:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ring_we       = 1'b0;
    ring_waddr    = cnt[SLOT_W-1:0];
    div_req.start = 1'b0;
    div_req.num   = (state == ST_DECIDE) ? DIV_W'(sum) : DIV_W'(prod);
    div_req.den   = (state == ST_DECIDE) ? DIV_DEN_W'(MEAN_DEN) : DIV_DEN_W'(RAMP_DEN);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_missing ? ST_DONE : ST_MUL_FIT;
        end
      end
      ST_MUL_FIT: begin
        state_next = ST_FIT;
      end
      ST_FIT: begin
        state_next = started ? ST_SWEEP : ST_FILL;
      end
      ST_FILL: begin
        ring_we = 1'b1;
        if (cnt == SWEEP_W'(HISTORY_DEPTH - 1)) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (cnt == SWEEP_W'(HISTORY_DEPTH)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (pass) begin
          ring_we    = 1'b1;
          ring_waddr = slot_inc;
          state_next = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_rsp.done) begin
          state_next = ST_EST;
        end
      end
      ST_EST: begin
        state_next = replace ? ST_DONE : ST_MUL_RAMP;
      end
      ST_MUL_RAMP: begin
        state_next = ST_RAMP_START;
      end
      ST_RAMP_START: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV_RAMP;
      end
      ST_DIV_RAMP: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  gafb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_slope      <= FIT_SLOPE_RST;
      fit_intercept  <= FIT_INTERCEPT_RST;
      jump_threshold <= JUMP_THRESHOLD_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIT_SLOPE) begin
        fit_slope <= cfg_data[SLOPE_W-1:0];
      end
      if (cfg_index == CFG_FIT_INTERCEPT) begin
        fit_intercept <= $signed(cfg_data[ALT_W-1:0]);
      end
      if (cfg_index == CFG_JUMP_THRESHOLD) begin
        jump_threshold <= cfg_data[THR_W-1:0];
      end
    end
  end

  // Offset memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= offset;
    end
    rd_data <= ring[ring_raddr];
  end

  // Per-item control state
  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      good_count   <= '0;
      jump_latched <= 1'b0;
      newest_slot  <= '0;
      ramp_step    <= '0;
    end else begin
      if (state == ST_FILL && cnt == SWEEP_W'(HISTORY_DEPTH - 1)) begin
        started <= 1'b1;
      end
      if (state == ST_DECIDE) begin
        good_count <= gc_calc;
        if (jl_set) begin
          jump_latched <= 1'b1;
        end
        if (pass) begin
          jump_latched <= 1'b0;
          newest_slot  <= slot_inc;
        end
      end
      if (state == ST_EST) begin
        if (replace) begin
          ramp_step <= '0;
        end else if (ramp_step != CNT_MAX) begin
          ramp_step <= ramp_step + 1'b1;
        end
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    rd_ok  <= (state == ST_SWEEP) && (cnt < SWEEP_W'(HISTORY_DEPTH));
    rd_idx <= ring_raddr;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          in_r        <= in_data;
          res         <= '0;
          res_missing <= in_missing;
          res_subst   <= 1'b0;
        end
      end
      ST_MUL_FIT, ST_MUL_RAMP: begin
        prod <= mul_a * mul_b_s;
      end
      ST_FIT: begin
        fit <= FIT_W'(rnd_sh) + FIT_W'(fit_intercept);
        cnt <= '0;
        sum <= '0;
      end
      ST_FILL: begin
        cnt <= (cnt == SWEEP_W'(HISTORY_DEPTH - 1)) ? '0 : cnt + 1'b1;
      end
      ST_SWEEP: begin
        cnt <= cnt + 1'b1;
        // Sum every entry except the newest, which is kept for the jump check
        if (rd_ok) begin
          if (rd_idx == newest_slot) begin
            ring_slot <= rd_data;
          end else begin
            sum <= sum + SUM_W'(rd_data);
          end
        end
      end
      ST_DECIDE: begin
        res_missing <= 1'b0;
        res_subst   <= !pass;
        res         <= RES_W'(in_r.gps_alt);
      end
      ST_DIV_MEAN: begin
        if (div_rsp.done) begin
          est <= EST_W'(fit) + EST_W'(div_rsp.quot);
        end
      end
      ST_EST: begin
        res <= RES_W'(est);
      end
      ST_DIV_RAMP: begin
        if (div_rsp.done) begin
          res <= RES_W'(est) + RES_W'(div_rsp.quot);
        end
      end
      default: begin
      end
    endcase
  end

  // Result saturation to the altitude range
  always_comb begin
    if (res > RES_W'(ALT_MAX_V)) begin
      res_sat = ALT_MAX_V;
    end else if (res < RES_W'(ALT_MIN_V)) begin
      res_sat = ALT_MIN_V;
    end else begin
      res_sat = ALT_W'(res);
    end
  end

  // Output register
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.corrected_alt  <= res_sat;
      out_data.result_missing <= res_missing;
      out_data.substituted    <= res_subst;
    end
  end

endmodule

@@ design/gafb_chk.sv @@
`include "gps_altitude_fallback_blender_assert.svh"

// Port-level checks for the altitude blender.
module gafb_chk
  import gafb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result item holds
  `GAFB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  // A missing-altitude result carries a zero altitude and no substitution
  `GAFB_ASSERT_IMP(a_missing_shape, out_valid && out_data.result_missing, (out_data.corrected_alt == 0) && !out_data.substituted, "bad missing-altitude result")

  // The block is not ready in the cycle after taking an item
  `GAFB_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after an item was accepted")

endmodule

bind gps_altitude_fallback_blender gafb_chk u_gafb_chk (.*);

@@ dv/gps_altitude_fallback_blender_test.sv @@
`timescale 1ns / 1ps

module gps_altitude_fallback_blender_test;
  import gafb_pkg::*;

  // Wider copies of the saturation limits for the predictor
  localparam longint ALT_HI = ALT_MAX_V;
  localparam longint ALT_LO = ALT_MIN_V;
  localparam longint OFF_HI = OFF_MAX_V;
  localparam longint OFF_LO = OFF_MIN_V;
  localparam int     CNT_TOP = CNT_MAX;

  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Kinds of generated samples
  typedef enum int {
    K_GOOD,
    K_MISSING,
    K_BAD_STATUS,
    K_BAD_MODE,
    K_JUMP,
    K_NOISE
  } stim_kind_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  gps_altitude_fallback_blender u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies, as the block holds them
  longint slope_cfg = FIT_SLOPE_RST;
  longint icpt_cfg  = FIT_INTERCEPT_RST;
  longint thr_cfg   = JUMP_THRESHOLD_RST;

  // Blender state as predicted
  bit     started_q;
  int     good_cnt;
  bit     jump_lat;
  int     newest_q;
  longint offset_hist [HISTORY_DEPTH];
  int     ramp_cnt;

  in_t    sample_q [$];
  out_t   alt_expect_q [$];
  out_t   want_r;

  // Stimulus track and run bookkeeping
  longint track_ref;
  longint track_off;
  bit     calm;
  bit     in_taken;
  int     errors;
  int     samples_in;
  int     results_seen;
  int     n_pass, n_est, n_ramp, n_missing, n_settings;
  int     hold_left;
  bit     hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [ALT_W-1:0] to_alt(longint v);
    longint c;
    c = clamp(v, ALT_LO, ALT_HI);
    return c[ALT_W-1:0];
  endfunction

  // Reference-to-GPS fit, rounded to nearest with ties upward
  function automatic longint fit_of(longint ref_v);
    return ((ref_v * slope_cfg + 32768) >>> SLOPE_FRAC) + icpt_cfg;
  endfunction

  // Nearest quotient, ties away from zero, d > 0
  function automatic longint div_near(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  task automatic report(input string msg);
    if (errors < 100) $display("%0t ns mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Work out the result of one accepted sample and advance the state
  task automatic predict_blend(input in_t s);
    out_t   r;
    longint gps, ref_v, fit, offset, dev, sum, est, res;
    int     slot;
    bit     subst;
    gps   = $signed(s.gps_alt);
    ref_v = $signed(s.ref_alt);
    subst = 1'b0;
    r     = '0;
    if (s.gps_alt_missing || s.ref_alt_missing) begin
      r.result_missing = 1'b1;
      alt_expect_q.push_back(r);
      n_missing++;
      return;
    end
    fit    = fit_of(ref_v);
    offset = clamp(gps - fit, OFF_LO, OFF_HI);
    slot   = newest_q % HISTORY_DEPTH;
    if (!started_q) begin
      foreach (offset_hist[i]) offset_hist[i] = offset;
      started_q = 1'b1;
    end
    if (good_cnt < CNT_TOP) good_cnt++;
    if (!(s.gps_status == GOOD_STATUS_NONE || s.gps_status == GOOD_STATUS_ALT) ||
        s.gps_mode < MIN_GOOD_MODE)
      good_cnt = 0;
    // one-shot jump detection against the newest offset
    dev = gps - (fit + offset_hist[slot]);
    if (dev < 0) dev = -dev;
    if (!jump_lat && dev > thr_cfg) begin
      good_cnt = 0;
      jump_lat = 1'b1;
    end
    if (good_cnt < GOOD_WAIT) begin
      sum = 0;
      foreach (offset_hist[i]) sum += offset_hist[i];
      sum -= offset_hist[slot];
      est = fit + div_near(sum, MEAN_DEN);
      if (good_cnt < RAMP_DELAY || s.gps_mode < MIN_GOOD_MODE) begin
        res      = est;
        ramp_cnt = 0;
        n_est++;
      end else begin
        if (ramp_cnt < CNT_TOP) ramp_cnt++;
        res = est + div_near(ramp_cnt * (gps - est), RAMP_DEN);
        n_ramp++;
      end
      subst = 1'b1;
    end else begin
      jump_lat          = 1'b0;
      res               = gps;
      slot              = (slot + 1) % HISTORY_DEPTH;
      newest_q          = slot;
      offset_hist[slot] = offset;
      n_pass++;
    end
    r.corrected_alt = to_alt(res);
    r.substituted   = subst;
    alt_expect_q.push_back(r);
  endtask

  function automatic in_t build(longint gps, longint ref_v, logic [STATUS_W-1:0] status,
                                logic [MODE_W-1:0] mode);
    in_t s;
    s            = '0;
    s.gps_alt    = to_alt(gps);
    s.ref_alt    = to_alt(ref_v);
    s.gps_status = status;
    s.gps_mode   = mode;
    return s;
  endfunction

  // One sample of the given kind along the current flight track
  function automatic in_t make_item(stim_kind_t k);
    in_t    s;
    longint jit, g;
    track_ref = clamp(track_ref + longint'($urandom_range(0, 4000)) - 2000, ALT_LO, ALT_HI);
    jit = thr_cfg / 4;
    if (jit > 2000) jit = 2000;
    g = fit_of(track_ref) + track_off + longint'($urandom_range(0, 2 * jit)) - jit;
    s = build(g, track_ref, $urandom_range(1) ? GOOD_STATUS_ALT : GOOD_STATUS_NONE,
              MODE_W'($urandom_range(MIN_GOOD_MODE, 15)));
    case (k)
      K_MISSING: begin
        {s.gps_alt_missing, s.ref_alt_missing} = 2'($urandom_range(1, 3));
        if ($urandom_range(1)) s.gps_alt = ALT_W'($urandom);
      end
      K_BAD_STATUS: begin
        s.gps_status = STATUS_W'($urandom_range(1, 65535));
        if (s.gps_status == GOOD_STATUS_ALT) s.gps_status = ~GOOD_STATUS_ALT;
        s.gps_mode = MODE_W'($urandom_range(0, 15));
      end
      K_BAD_MODE: begin
        s.gps_mode = MODE_W'($urandom_range(0, MIN_GOOD_MODE - 1));
      end
      K_JUMP: begin
        jit = thr_cfg + 1 + longint'($urandom_range(0, 100000));
        s.gps_alt = to_alt(fit_of(track_ref) + track_off + ($urandom_range(1) ? jit : -jit));
      end
      K_NOISE: begin
        s.gps_alt         = ALT_W'($urandom);
        s.ref_alt         = ALT_W'($urandom);
        s.gps_status      = STATUS_W'($urandom);
        s.gps_mode        = MODE_W'($urandom);
        s.gps_alt_missing = ($urandom_range(7) == 0);
        s.ref_alt_missing = ($urandom_range(7) == 0);
      end
      default: ;
    endcase
    return s;
  endfunction

  // Runs of good samples broken by short disturbances
  task automatic queue_flight(input int n);
    int         made;
    stim_kind_t k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(3) == 0) begin
        track_ref = $signed(ALT_W'($urandom));
        track_off = longint'($urandom_range(0, 100000)) - 50000;
      end
      repeat ($urandom_range(3, 25)) begin
        sample_q.push_back(make_item(($urandom_range(19) == 0) ? K_MISSING : K_GOOD));
        made++;
      end
      repeat ($urandom_range(1, 5)) begin
        k = stim_kind_t'($urandom_range(K_MISSING, K_NOISE));
        sample_q.push_back(make_item(k));
        made++;
      end
    end
  endtask

  // Block is idle once every sample went in and every result came out
  task automatic wait_idle();
    @(posedge clk);
    while (sample_q.size() != 0 || in_valid || alt_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FIT_SLOPE:      slope_cfg = val[SLOPE_W-1:0];
      CFG_FIT_INTERCEPT:  icpt_cfg  = $signed(val[ALT_W-1:0]);
      CFG_JUMP_THRESHOLD: thr_cfg   = val[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input longint slope, input longint icpt, input longint thr);
    wait_idle();
    write_reg(CFG_FIT_SLOPE, CFG_W'(slope));
    write_reg(CFG_FIT_INTERCEPT, CFG_W'(icpt));
    write_reg(CFG_JUMP_THRESHOLD, CFG_W'(thr));
    n_settings++;
  endtask

  // Input driver: next pending sample at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
        in_data  <= sample_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output ready, with one long hold-off while samples are still queued
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 400 && sample_q.size() > 5) begin
      hold_done = 1'b1;
      hold_left = 299;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // Monitor: predict on input items, check output items
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_blend(in_data);
        in_taken = 1'b1;
        samples_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (alt_expect_q.size() == 0) begin
          report("result item with no sample waiting for it");
        end else begin
          want_r = alt_expect_q.pop_front();
          if (out_data.corrected_alt !== want_r.corrected_alt)
            report($sformatf("corrected_alt got %0d want %0d", $signed(out_data.corrected_alt),
                             $signed(want_r.corrected_alt)));
          if (out_data.result_missing !== want_r.result_missing)
            report($sformatf("result_missing got %b want %b", out_data.result_missing,
                             want_r.result_missing));
          if (out_data.substituted !== want_r.substituted)
            report($sformatf("substituted got %b want %b", out_data.substituted,
                             want_r.substituted));
        end
      end
    end
  end

  initial begin
    longint base;
    track_ref = 0;
    track_off = 0;
    n_settings = 1;

    // Missing altitudes, including before the ring is filled
    sample_q.push_back(build(ALT_HI, ALT_LO, GOOD_STATUS_NONE, MIN_GOOD_MODE));
    sample_q[$].gps_alt_missing = 1'b1;
    sample_q.push_back(build(ALT_LO, ALT_HI, GOOD_STATUS_ALT, 4'd15));
    sample_q[$].ref_alt_missing = 1'b1;
    sample_q.push_back(build(-1, -1, 16'hffff, 4'd0));
    sample_q[$].gps_alt_missing = 1'b1;
    sample_q[$].ref_alt_missing = 1'b1;

    // Ring fill, replacement, ramp and then pass-through
    for (int i = 0; i < 12; i++) begin
      base = i * 25600;
      sample_q.push_back(build(fit_of(base) + 300, base,
                               i[0] ? GOOD_STATUS_ALT : GOOD_STATUS_NONE,
                               MODE_W'(MIN_GOOD_MODE + i)));
    end
    // Jump, bad status, bad modes, field extremes
    sample_q.push_back(build(fit_of(base) + thr_cfg + 5000, base, GOOD_STATUS_NONE, 4'd8));
    sample_q.push_back(build(fit_of(base), base, 16'h0001, 4'd8));
    sample_q.push_back(build(fit_of(base), base, GOOD_STATUS_NONE, 4'd3));
    sample_q.push_back(build(fit_of(base), base, GOOD_STATUS_ALT, 4'd0));
    sample_q.push_back(build(ALT_HI, ALT_LO, GOOD_STATUS_NONE, 4'd15));
    sample_q.push_back(build(ALT_LO, ALT_HI, GOOD_STATUS_ALT, 4'd4));

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    queue_flight(200);

    // No jump limit, unity slope; also a write to the unused index
    set_config(65536, 0, THR_W'('1));
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    queue_flight(230);

    // Top slope and intercept, zero threshold
    set_config(SLOPE_W'('1), ALT_HI, 0);
    queue_flight(230);

    // Zero slope, bottom intercept
    set_config(0, ALT_LO, 12800);
    queue_flight(230);

    // Random registers, no idling on either side
    set_config($urandom_range(0, 131071), longint'($urandom_range(0, 200000)) - 100000,
               $urandom_range(0, 40000));
    calm = 1'b1;
    queue_flight(230);
    wait_idle();
    calm = 1'b0;

    // Back to the power-up registers
    set_config(FIT_SLOPE_RST, FIT_INTERCEPT_RST, JUMP_THRESHOLD_RST);
    queue_flight(280);

    wait_idle();
    repeat (50) @(posedge clk);

    $display("Ran %0d samples over %0d register settings: %0d pass-through, %0d replaced,",
             samples_in, n_settings, n_pass, n_est);
    $display("%0d ramped, %0d missing; %0d results checked, %0d mismatches.",
             n_ramp, n_missing, results_seen, errors);
    if (errors == 0 && alt_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
